// ===== hdl/dmfic_pkg.sv =====
// Shared types and constants for the dual-mode force / impedance controller.
package dmfic_pkg;

  localparam int unsigned AddrW   = 5;    // 8 registers, 4-byte stride
  localparam int unsigned DataW   = 32;
  localparam int unsigned ErrW    = 33;   // target - measured
  localparam int unsigned DiffW   = 34;   // err - last_err
  localparam int unsigned SumW    = 48;   // saturating integral
  localparam int unsigned GdW     = 42;   // gain_d * 1000
  localparam int unsigned AccW    = 81;   // full-precision PID sum
  localparam int unsigned FracW   = 16;

  localparam logic [31:0]        StartMs  = 32'd1000;
  localparam logic signed [10:0] DerScale = 11'sd1000;

  typedef enum logic [2:0] {
    REG_CTRL_MODE     = 3'd0,
    REG_TARGET_FORCE  = 3'd1,
    REG_GAIN_P        = 3'd2,
    REG_GAIN_I        = 3'd3,
    REG_GAIN_D        = 3'd4,
    REG_REST_POSITION = 3'd5,
    REG_SPRING_GAIN   = 3'd6,
    REG_DAMPING_GAIN  = 3'd7
  } reg_idx_t;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic                    ctrl_mode;
    logic signed [31:0]      target_force;
    logic signed [31:0]      gain_p;
    logic signed [31:0]      gain_i;
    logic signed [GdW-1:0]   gain_d_x1k;
    logic signed [31:0]      rest_position;
    logic signed [31:0]      spring_gain;
    logic signed [31:0]      damping_gain;
  } cfg_t;

  // Per-stage load enables from the top-level handshake
  typedef struct packed {
    logic adv_s1;   // stage 1 request moves on this cycle
    logic ld_s2;
    logic ld_s3;
    logic ld_s4;
    logic ld_s5;
  } pipe_ctl_t;

endpackage

// ===== hdl/dmfic_cfg.sv =====
// APB register file; also keeps gain_d pre-scaled by the 1 ms derivative factor.
module dmfic_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dmfic_pkg::AddrW-1:0]       paddr,
  input  logic [dmfic_pkg::DataW-1:0]       pwdata,
  output logic [dmfic_pkg::DataW-1:0]       prdata,
  output logic                              pready,
  output dmfic_pkg::cfg_t                   cfg
);

  logic                        ctrl_mode_r;
  logic signed [31:0]          target_force_r;
  logic signed [31:0]          gain_p_r;
  logic signed [31:0]          gain_i_r;
  logic signed [31:0]          gain_d_r;
  logic signed [dmfic_pkg::GdW-1:0] gain_d_x1k_r;
  logic signed [31:0]          rest_position_r;
  logic signed [31:0]          spring_gain_r;
  logic signed [31:0]          damping_gain_r;
  logic                        wr_en;
  dmfic_pkg::reg_idx_t         idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = dmfic_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_mode_r     <= 1'b0;
      target_force_r  <= '0;
      gain_p_r        <= '0;
      gain_i_r        <= '0;
      gain_d_r        <= '0;
      gain_d_x1k_r    <= '0;
      rest_position_r <= '0;
      spring_gain_r   <= '0;
      damping_gain_r  <= '0;
    end else if (wr_en) begin
      case (idx)
        dmfic_pkg::REG_CTRL_MODE:     ctrl_mode_r     <= pwdata[0];
        dmfic_pkg::REG_TARGET_FORCE:  target_force_r  <= $signed(pwdata);
        dmfic_pkg::REG_GAIN_P:        gain_p_r        <= $signed(pwdata);
        dmfic_pkg::REG_GAIN_I:        gain_i_r        <= $signed(pwdata);
        dmfic_pkg::REG_GAIN_D: begin
          gain_d_r     <= $signed(pwdata);
          gain_d_x1k_r <= dmfic_pkg::GdW'($signed(pwdata)) *
                          dmfic_pkg::GdW'(dmfic_pkg::DerScale);
        end
        dmfic_pkg::REG_REST_POSITION: rest_position_r <= $signed(pwdata);
        dmfic_pkg::REG_SPRING_GAIN:   spring_gain_r   <= $signed(pwdata);
        dmfic_pkg::REG_DAMPING_GAIN:  damping_gain_r  <= $signed(pwdata);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dmfic_pkg::REG_CTRL_MODE:     prdata = {31'd0, ctrl_mode_r};
      dmfic_pkg::REG_TARGET_FORCE:  prdata = target_force_r;
      dmfic_pkg::REG_GAIN_P:        prdata = gain_p_r;
      dmfic_pkg::REG_GAIN_I:        prdata = gain_i_r;
      dmfic_pkg::REG_GAIN_D:        prdata = gain_d_r;
      dmfic_pkg::REG_REST_POSITION: prdata = rest_position_r;
      dmfic_pkg::REG_SPRING_GAIN:   prdata = spring_gain_r;
      dmfic_pkg::REG_DAMPING_GAIN:  prdata = damping_gain_r;
      default:                      prdata = '0;
    endcase
  end

  assign cfg.ctrl_mode     = ctrl_mode_r;
  assign cfg.target_force  = target_force_r;
  assign cfg.gain_p        = gain_p_r;
  assign cfg.gain_i        = gain_i_r;
  assign cfg.gain_d_x1k    = gain_d_x1k_r;
  assign cfg.rest_position = rest_position_r;
  assign cfg.spring_gain   = spring_gain_r;
  assign cfg.damping_gain  = damping_gain_r;

endmodule

// ===== hdl/dmfic_err.sv =====
// Error stage: PID error, derivative difference, saturating integral and loop state.
module dmfic_err (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  dmfic_pkg::cfg_t                        cfg,
  input  dmfic_pkg::pipe_ctl_t                   ctl,
  input  logic signed [31:0]                     s1_force,
  input  logic signed [31:0]                     s1_angle,
  input  logic signed [31:0]                     s1_vel,
  input  logic                                   s1_on,
  output logic signed [dmfic_pkg::ErrW-1:0]      err_r,
  output logic signed [dmfic_pkg::DiffW-1:0]     diff_r,
  output logic signed [dmfic_pkg::SumW-1:0]      sum_r,
  output logic signed [dmfic_pkg::ErrW-1:0]      dpos_r,
  output logic signed [31:0]                     vel_r,
  output logic                                   on_r,
  output logic                                   mode_r
);

  logic signed [dmfic_pkg::ErrW-1:0]  last_error_r;
  logic signed [dmfic_pkg::SumW-1:0]  error_sum_r;
  logic signed [dmfic_pkg::ErrW-1:0]  err_nxt;
  logic signed [dmfic_pkg::DiffW-1:0] diff_nxt;
  logic signed [dmfic_pkg::SumW:0]    sum_wide;
  logic signed [dmfic_pkg::SumW-1:0]  sum_nxt;
  logic signed [dmfic_pkg::ErrW-1:0]  dpos_nxt;
  logic                               commit;

  assign err_nxt  = dmfic_pkg::ErrW'(cfg.target_force) - dmfic_pkg::ErrW'(s1_force);
  assign diff_nxt = dmfic_pkg::DiffW'(err_nxt) - dmfic_pkg::DiffW'(last_error_r);
  assign sum_wide = (dmfic_pkg::SumW+1)'(error_sum_r) + (dmfic_pkg::SumW+1)'(err_nxt);
  assign dpos_nxt = dmfic_pkg::ErrW'(cfg.rest_position) - dmfic_pkg::ErrW'(s1_angle);

  // clamp on overflow of the 48-bit integral
  always_comb begin
    if (sum_wide[dmfic_pkg::SumW] != sum_wide[dmfic_pkg::SumW-1]) begin
      sum_nxt = sum_wide[dmfic_pkg::SumW] ?
                {1'b1, {(dmfic_pkg::SumW-1){1'b0}}} :
                {1'b0, {(dmfic_pkg::SumW-1){1'b1}}};
    end else begin
      sum_nxt = sum_wide[dmfic_pkg::SumW-1:0];
    end
  end

  assign commit = ctl.adv_s1 && s1_on && !cfg.ctrl_mode;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_error_r <= '0;
      error_sum_r  <= '0;
    end else if (commit) begin
      last_error_r <= err_nxt;
      error_sum_r  <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_s2) begin
      err_r  <= err_nxt;
      diff_r <= diff_nxt;
      sum_r  <= sum_nxt;
      dpos_r <= dpos_nxt;
      vel_r  <= s1_vel;
      on_r   <= s1_on;
      mode_r <= cfg.ctrl_mode;
    end
  end

endmodule

// ===== hdl/dmfic_mac.sv =====
// Multiply-accumulate: split products, partial-sum reduction, final drive sum.
module dmfic_mac (
  input  logic                                   clk,
  input  dmfic_pkg::cfg_t                        cfg,
  input  dmfic_pkg::pipe_ctl_t                   ctl,
  input  logic signed [dmfic_pkg::ErrW-1:0]      err,
  input  logic signed [dmfic_pkg::DiffW-1:0]     diff,
  input  logic signed [dmfic_pkg::SumW-1:0]      sum,
  input  logic signed [dmfic_pkg::ErrW-1:0]      dpos,
  input  logic signed [31:0]                     vel,
  input  logic                                   on,
  input  logic                                   mode,
  output logic signed [dmfic_pkg::AccW-1:0]      acc_r,
  output logic                                   on_r
);

  // stage 3: products, wide operands split into a low (unsigned) and high part
  logic signed [64:0] pe_r;
  logic signed [56:0] ilo_r;
  logic signed [55:0] ihi_r;
  logic signed [55:0] dlo_r;
  logic signed [54:0] dhi_r;
  logic signed [64:0] ps_r;
  logic signed [63:0] pv_r;
  logic               on3_r;
  logic               mode3_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_s3) begin
      pe_r    <= err * cfg.gain_p;
      ilo_r   <= $signed({1'b0, sum[23:0]}) * cfg.gain_i;
      ihi_r   <= $signed(sum[47:24]) * cfg.gain_i;
      dlo_r   <= diff * $signed({1'b0, cfg.gain_d_x1k[20:0]});
      dhi_r   <= diff * $signed(cfg.gain_d_x1k[41:21]);
      ps_r    <= dpos * cfg.spring_gain;
      pv_r    <= cfg.damping_gain * vel;
      on3_r   <= on;
      mode3_r <= mode;
    end
  end

  // stage 4: recombine the split products
  logic signed [64:0] pe4_r;
  logic signed [79:0] pi_r;
  logic signed [75:0] pd_r;
  logic signed [65:0] imp_r;
  logic               on4_r;
  logic               mode4_r;

  always_ff @(posedge clk) begin
    if (ctl.ld_s4) begin
      pe4_r   <= pe_r;
      pi_r    <= (80'(ihi_r) <<< 24) + 80'(ilo_r);
      pd_r    <= (76'(dhi_r) <<< 21) + 76'(dlo_r);
      imp_r   <= 66'(ps_r) - 66'(pv_r);
      on4_r   <= on3_r;
      mode4_r <= mode3_r;
    end
  end

  // stage 5: mode select and final sum
  always_ff @(posedge clk) begin
    if (ctl.ld_s5) begin
      if (mode4_r) begin
        acc_r <= dmfic_pkg::AccW'(imp_r);
      end else begin
        acc_r <= dmfic_pkg::AccW'(pe4_r) + dmfic_pkg::AccW'(pi_r) +
                 dmfic_pkg::AccW'(pd_r);
      end
      on_r <= on4_r;
    end
  end

endmodule

// ===== hdl/dual_mode_force_impedance_ctrl.sv =====
// Top level of the dual-mode force / impedance joint controller.
//
// One request per control tick carries measured force, joint angle, joint
// velocity and time in ms; each request yields exactly one result, in order.
// Up to and including 1000 ms the result is drive_force = 0, drive_valid = 0
// and the loop state is untouched. After that, mode 0 runs PID on
// err = target_force - measured_force (derivative = err step * 1000, integral
// = 48-bit saturating sum, no anti-windup); mode 1 drives
// spring_gain*(rest_position - joint_angle) - damping_gain*joint_velocity.
// All Q16.16; the exact sum is floor-shifted by 16 and clamped to 32 bits.
// Throughput: one request per cycle while out_stall is low. The input register
// loads at the accepting edge, then the error stage, product stage, reduction
// stage, final-sum stage and saturating output register follow in that order.
// Each stage has its own valid bit, so bubbles close up and a request is still
// accepted while a finished result waits on out_stall if some stage is empty.
// The integral/last-error state updates as a request leaves the error stage,
// so back-to-back requests see each other's state with no extra wait. Registers
// sit at byte offsets 4*i; the user must write configuration only while the
// pipeline is empty, which the block itself does not enforce.
module dual_mode_force_impedance_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dmfic_pkg::AddrW-1:0] paddr,
  input  logic [dmfic_pkg::DataW-1:0] pwdata,
  output logic [dmfic_pkg::DataW-1:0] prdata,
  output logic                        pready,
  // request channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          in_measured_force,
  input  logic signed [31:0]          in_joint_angle,
  input  logic signed [31:0]          in_joint_velocity,
  input  logic [31:0]                 in_sim_time_ms,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [31:0]          out_drive_force,
  output logic                        out_drive_valid
);

  dmfic_pkg::cfg_t      cfg;
  dmfic_pkg::pipe_ctl_t ctl;

  // stage valid bits and per-stage ready (stage may load when empty or draining)
  logic v1_r, v2_r, v3_r, v4_r, v5_r, vo_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdyo;

  assign rdyo = !vo_r || !out_stall;
  assign rdy5 = !v5_r || rdyo;
  assign rdy4 = !v4_r || rdy5;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;

  assign in_stall = !rdy1;

  assign ctl.adv_s1 = v1_r && rdy2;
  assign ctl.ld_s2  = rdy2;
  assign ctl.ld_s3  = rdy3;
  assign ctl.ld_s4  = rdy4;
  assign ctl.ld_s5  = rdy5;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdy5) v5_r <= v4_r;
      if (rdyo) vo_r <= v5_r;
    end
  end

  // stage 1: input register; the time gate is resolved on the way in
  logic signed [31:0] force1_r;
  logic signed [31:0] angle1_r;
  logic signed [31:0] vel1_r;
  logic               on1_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      force1_r <= in_measured_force;
      angle1_r <= in_joint_angle;
      vel1_r   <= in_joint_velocity;
      on1_r    <= (in_sim_time_ms > dmfic_pkg::StartMs);
    end
  end

  dmfic_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic signed [dmfic_pkg::ErrW-1:0]  err2;
  logic signed [dmfic_pkg::DiffW-1:0] diff2;
  logic signed [dmfic_pkg::SumW-1:0]  sum2;
  logic signed [dmfic_pkg::ErrW-1:0]  dpos2;
  logic signed [31:0]                 vel2;
  logic                               on2;
  logic                               mode2;

  dmfic_err u_err (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .ctl      (ctl),
    .s1_force (force1_r),
    .s1_angle (angle1_r),
    .s1_vel   (vel1_r),
    .s1_on    (on1_r),
    .err_r    (err2),
    .diff_r   (diff2),
    .sum_r    (sum2),
    .dpos_r   (dpos2),
    .vel_r    (vel2),
    .on_r     (on2),
    .mode_r   (mode2)
  );

  logic signed [dmfic_pkg::AccW-1:0] acc5;
  logic                              on5;

  dmfic_mac u_mac (
    .clk   (clk),
    .cfg   (cfg),
    .ctl   (ctl),
    .err   (err2),
    .diff  (diff2),
    .sum   (sum2),
    .dpos  (dpos2),
    .vel   (vel2),
    .on    (on2),
    .mode  (mode2),
    .acc_r (acc5),
    .on_r  (on5)
  );

  // output register: floor shift by 16 and clamp to 32 bits. In range when
  // every bit from the result sign upward matches the accumulator sign.
  logic signed [31:0] drive_force_r;
  logic               drive_valid_r;
  logic signed [31:0] sat_nxt;
  logic               hi_ones;
  logic               hi_zeros;

  assign hi_ones  = &acc5[dmfic_pkg::AccW-1:dmfic_pkg::FracW+31];
  assign hi_zeros = ~|acc5[dmfic_pkg::AccW-1:dmfic_pkg::FracW+31];

  always_comb begin
    if (hi_ones || hi_zeros) begin
      sat_nxt = acc5[dmfic_pkg::FracW+31:dmfic_pkg::FracW];
    end else if (acc5[dmfic_pkg::AccW-1]) begin
      sat_nxt = 32'sh8000_0000;
    end else begin
      sat_nxt = 32'sh7fff_ffff;
    end
  end

  always_ff @(posedge clk) begin
    if (rdyo) begin
      drive_force_r <= on5 ? sat_nxt : '0;
      drive_valid_r <= on5;
    end
  end

  assign out_valid       = vo_r;
  assign out_drive_force = drive_force_r;
  assign out_drive_valid = drive_valid_r;

  // no back-pressure at the output means the whole pipeline can move
  a_no_stall_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled with output free");

  // an empty input stage always takes a request
  a_s1_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> !in_stall)
    else $error("input stalled with stage 1 empty");

  // gated ticks carry a zero force
  a_gated_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_drive_valid) |-> (out_drive_force == 32'sd0))
    else $error("nonzero force on gated tick");

  // a result held under stall with every stage full stalls the input
  a_hold_full: assert property (@(posedge clk) disable iff (!rst_n)
    (vo_r && out_stall && v5_r && v4_r && v3_r && v2_r && v1_r) |-> in_stall)
    else $error("request accepted into a full pipeline");

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the dual-mode force / impedance joint controller.
`timescale 1ns / 100ps

module testbench;

  // Control mode codes as written to ctrl_mode
  localparam logic ModePid       = 1'b0;
  localparam logic ModeImpedance = 1'b1;

  localparam int PipeDepth  = 5;        // acceptance to out_valid
  localparam int CycleLimit = 200_000;  // far above a fully stalled run

  localparam longint SumHi = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumLo = -SumHi - 1;
  localparam logic signed [127:0] DriveHi = 128'sh7FFF_FFFF;
  localparam logic signed [127:0] DriveLo = -128'sh8000_0000;
  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;
  localparam logic [31:0] QOne = 32'h0001_0000;

  typedef struct packed {
    logic signed [31:0] force_cmd;
    logic               issued;
  } drive_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // configuration port
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [dmfic_pkg::AddrW-1:0]   paddr = '0;
  logic [dmfic_pkg::DataW-1:0]   pwdata = '0;
  logic [dmfic_pkg::DataW-1:0]   prdata;
  logic                          pready;

  // request channel
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [31:0] in_measured_force = '0;
  logic signed [31:0] in_joint_angle = '0;
  logic signed [31:0] in_joint_velocity = '0;
  logic [31:0]        in_sim_time_ms = '0;

  // result channel
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_drive_force;
  logic               out_drive_valid;

  // Controller shadow: registers plus loop state, updated as requests are accepted
  logic               cur_mode = ModePid;
  logic signed [31:0] setpoint = '0;
  logic signed [31:0] kp = '0;
  logic signed [31:0] ki = '0;
  logic signed [31:0] kd = '0;
  logic signed [31:0] home_pos = '0;
  logic signed [31:0] stiffness = '0;
  logic signed [31:0] damping = '0;
  logic signed [32:0] prev_err = '0;
  logic signed [47:0] err_total = '0;

  drive_t drive_q[$];     // expected drive commands, oldest first

  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;       // chance (percent) of starting an idle burst, both sides
  int stall_left = 0;
  int n_requests = 0;
  int n_driven = 0;
  int n_held = 0;
  int n_reg_writes = 0;
  int n_pid = 0;
  int n_imp = 0;

  dual_mode_force_impedance_ctrl i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_measured_force (in_measured_force),
    .in_joint_angle    (in_joint_angle),
    .in_joint_velocity (in_joint_velocity),
    .in_sim_time_ms    (in_sim_time_ms),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive_force   (out_drive_force),
    .out_drive_valid   (out_drive_valid)
  );

  always #2 clk = ~clk;

  // Run guard: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: timeout, %0d drive commands still outstanding", $time, drive_q.size());
      $display("** dual_mode_force_impedance_ctrl: FAILED **");
      $finish;
    end
  end

  // Result-side backpressure: random bursts of stalled cycles
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(10);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every delivered result against the oldest expectation
  always @(posedge clk) begin : check_results
    drive_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (drive_q.size() == 0) begin
        errors++;
        if (errors < 20)
          $display("%0t: unexpected result, expected none, actual force=%h valid=%b",
                   $time, out_drive_force, out_drive_valid);
      end else begin
        want = drive_q.pop_front();
        if (out_drive_force !== want.force_cmd) begin
          errors++;
          if (errors < 20)
            $display("%0t: drive_force mismatch, expected %h, actual %h",
                     $time, want.force_cmd, out_drive_force);
        end
        if (out_drive_valid !== want.issued) begin
          errors++;
          if (errors < 20)
            $display("%0t: drive_valid mismatch, expected %b, actual %b",
                     $time, want.issued, out_drive_valid);
        end
      end
    end
  end

  function automatic logic signed [127:0] wide(input longint x);
    return x;
  endfunction

  // One control tick of the controller; advances the PID state when it runs
  function automatic drive_t predict_drive(input logic signed [31:0] meas,
                                           input logic signed [31:0] ang,
                                           input logic signed [31:0] vel,
                                           input logic [31:0] t_ms);
    drive_t r;
    longint err;
    longint der;
    longint total;
    logic signed [127:0] acc;
    logic signed [127:0] q;
    r.force_cmd = '0;
    r.issued = 1'b0;
    // control is held off through the first 1000 ms, state untouched
    if (t_ms <= dmfic_pkg::StartMs) return r;
    if (cur_mode == ModePid) begin
      err = longint'(setpoint) - longint'(meas);
      der = (err - longint'(prev_err)) * longint'(dmfic_pkg::DerScale);
      total = longint'(err_total) + err;
      // integral saturates, no anti-windup
      if (total > SumHi) total = SumHi;
      if (total < SumLo) total = SumLo;
      err_total = total[47:0];
      prev_err = err[32:0];
      acc = wide(err) * wide(kp) + wide(total) * wide(ki) + wide(der) * wide(kd);
    end else begin
      acc = wide(longint'(home_pos) - longint'(ang)) * wide(stiffness)
          - wide(damping) * wide(vel);
    end
    q = acc >>> dmfic_pkg::FracW;   // floor
    if (q > DriveHi) r.force_cmd = QMax;
    else if (q < DriveLo) r.force_cmd = QMin;
    else r.force_cmd = q[31:0];
    r.issued = 1'b1;
    return r;
  endfunction

  // Biased Q16.16 value: extremes, zero, small (+-4.0) or full range
  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return QMax;
      1: return QMin;
      2: return 32'h0;
      3, 4: return 32'($urandom_range(524287)) - 32'd262144;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [31:0] pick_time();
    case ($urandom_range(9))
      0: return $urandom_range(1000);
      1: return dmfic_pkg::StartMs + $urandom_range(1);   // start boundary
      2: return 32'hFFFF_FFFF;
      default: return $urandom_range(32'hFFFF_FFFF, 1001);
    endcase
  endfunction

  // APB write: setup then access; shadow updated at the accepting edge
  task automatic write_reg(input dmfic_pkg::reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      dmfic_pkg::REG_CTRL_MODE:     cur_mode = val[0];
      dmfic_pkg::REG_TARGET_FORCE:  setpoint = val;
      dmfic_pkg::REG_GAIN_P:        kp = val;
      dmfic_pkg::REG_GAIN_I:        ki = val;
      dmfic_pkg::REG_GAIN_D:        kd = val;
      dmfic_pkg::REG_REST_POSITION: home_pos = val;
      dmfic_pkg::REG_SPRING_GAIN:   stiffness = val;
      dmfic_pkg::REG_DAMPING_GAIN:  damping = val;
      default: ;
    endcase
    n_reg_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Send one request, with an optional idle burst ahead of it
  task automatic send_request(input logic [31:0] meas, input logic [31:0] ang,
                              input logic [31:0] vel, input logic [31:0] t_ms);
    drive_t want;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(10)) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_measured_force <= meas;
    in_joint_angle <= ang;
    in_joint_velocity <= vel;
    in_sim_time_ms <= t_ms;
    do @(posedge clk); while (in_stall);
    want = predict_drive(meas, ang, vel, t_ms);
    drive_q.push_back(want);
    n_requests++;
    if (want.issued) begin
      n_driven++;
      if (cur_mode == ModePid) n_pid++;
      else n_imp++;
    end else begin
      n_held++;
    end
  endtask

  // Stop sending and let the pipeline empty out completely
  task automatic wait_pipeline_empty();
    @(negedge clk);
    in_valid <= 1'b0;
    while (drive_q.size() != 0) @(posedge clk);
    repeat (PipeDepth + 4) @(posedge clk);
  endtask

  // Hold-off window: nothing is driven and the PID state must not move, then the first driven ticks
  task automatic test_start_gate();
    write_reg(dmfic_pkg::REG_CTRL_MODE, 32'(ModePid));
    write_reg(dmfic_pkg::REG_TARGET_FORCE, QMax);
    write_reg(dmfic_pkg::REG_GAIN_P, QMax);
    write_reg(dmfic_pkg::REG_GAIN_I, QMin);
    write_reg(dmfic_pkg::REG_GAIN_D, QMax);
    send_request(QMin, QMax, QMin, 32'd0);
    send_request(QMax, QMin, QMax, 32'd999);
    send_request(QMin, 32'h0, 32'h0, dmfic_pkg::StartMs);
    send_request(32'h0, 32'h0, 32'h0, dmfic_pkg::StartMs + 1);   // first driven tick
    send_request(QMin, 32'h0, 32'h0, 32'hFFFF_FFFF);
    wait_pipeline_empty();
  endtask

  // PID with extreme errors, derivative steps and both output clamps
  task automatic test_pid_directed();
    write_reg(dmfic_pkg::REG_TARGET_FORCE, QMin);
    write_reg(dmfic_pkg::REG_GAIN_P, QOne);
    write_reg(dmfic_pkg::REG_GAIN_I, 32'd1);
    write_reg(dmfic_pkg::REG_GAIN_D, 32'h0000_0041);   // ~0.001, undoes the x1000
    send_request(QMax, 32'h0, 32'h0, 32'd1001);
    send_request(32'h0, 32'h0, 32'h0, 32'd1002);
    send_request(QMin, 32'h0, 32'h0, 32'd1003);
    send_request(QMax, 32'h0, 32'h0, 32'd1004);
    wait_pipeline_empty();
    write_reg(dmfic_pkg::REG_GAIN_P, QMin);
    write_reg(dmfic_pkg::REG_GAIN_D, QMin);
    send_request(QMax, 32'h0, 32'h0, 32'd1005);
    send_request(QMin, 32'h0, 32'h0, 32'd1006);
    wait_pipeline_empty();
  endtask

  // Impedance drive, saturation both ways, then check PID state was kept
  task automatic test_impedance();
    write_reg(dmfic_pkg::REG_CTRL_MODE, 32'(ModeImpedance));
    write_reg(dmfic_pkg::REG_REST_POSITION, QMax);
    write_reg(dmfic_pkg::REG_SPRING_GAIN, QMax);
    write_reg(dmfic_pkg::REG_DAMPING_GAIN, QMin);
    send_request(32'h0, QMin, QMax, 32'd2000);
    send_request(QMax, QMax, 32'h0, 32'd2001);
    send_request(QMin, QMax, QMax, 32'd2002);
    wait_pipeline_empty();
    write_reg(dmfic_pkg::REG_SPRING_GAIN, QMin);
    write_reg(dmfic_pkg::REG_DAMPING_GAIN, QMax);
    send_request(32'h0, QMin, QMax, 32'd2003);
    send_request(32'h0, QMax, QMin, 32'd2004);
    send_request(32'h0, QOne, 32'hFFFF_0000, 32'd2005);
    wait_pipeline_empty();
    write_reg(dmfic_pkg::REG_CTRL_MODE, 32'(ModePid));
    send_request(32'h0, 32'h0, 32'h0, 32'd2006);
    wait_pipeline_empty();
  endtask

  // Random register settings, random ticks, idling on both sides
  task automatic test_random_ticks();
    int n_phases;
    int per_phase;
    n_phases = 6;
    per_phase = 235;
    for (int ph = 0; ph < n_phases; ph++) begin
      idle_pct = (ph == 2) ? 0 : (ph % 2 == 0) ? 10 : 30;
      write_reg(dmfic_pkg::REG_CTRL_MODE, (ph < 2) ? 32'(ph) : 32'($urandom_range(1)));
      write_reg(dmfic_pkg::REG_TARGET_FORCE, pick_value());
      write_reg(dmfic_pkg::REG_GAIN_P, pick_value());
      write_reg(dmfic_pkg::REG_GAIN_I, pick_value());
      write_reg(dmfic_pkg::REG_GAIN_D, pick_value());
      write_reg(dmfic_pkg::REG_REST_POSITION, pick_value());
      write_reg(dmfic_pkg::REG_SPRING_GAIN, pick_value());
      write_reg(dmfic_pkg::REG_DAMPING_GAIN, pick_value());
      for (int k = 0; k < per_phase; k++) begin
        // sender holds off once per phase until everything is back
        if (k == per_phase / 2) wait_pipeline_empty();
        send_request(pick_value(), pick_value(), pick_value(), pick_time());
      end
      wait_pipeline_empty();
    end
  endtask

  // Wind the integral up with max-size errors one way, then back the other;
  // with gain_i as 1 LSB the output tracks sum >> 16. Back to back, no idling.
  task automatic test_integral_windup();
    idle_pct = 0;
    write_reg(dmfic_pkg::REG_CTRL_MODE, 32'(ModePid));
    write_reg(dmfic_pkg::REG_GAIN_P, 32'h0);
    write_reg(dmfic_pkg::REG_GAIN_I, 32'd1);
    write_reg(dmfic_pkg::REG_GAIN_D, 32'h0);
    write_reg(dmfic_pkg::REG_TARGET_FORCE, QMin);
    repeat (48) send_request(QMax, 32'h0, 32'h0, 32'd5000);
    wait_pipeline_empty();
    write_reg(dmfic_pkg::REG_TARGET_FORCE, QMax);
    repeat (96) send_request(QMin, 32'h0, 32'h0, 32'd6000);
    wait_pipeline_empty();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_start_gate();
    test_pid_directed();
    test_impedance();
    test_random_ticks();
    test_integral_windup();
    $display("Run covered %0d requests: %0d PID and %0d impedance drives, %0d held off.",
             n_requests, n_pid, n_imp, n_held);
    $display("%0d register writes; integral wound up both ways at full rate to finish.",
             n_reg_writes);
    if (errors == 0) begin
      $display("** dual_mode_force_impedance_ctrl: PASSED **");
    end else begin
      $display("** dual_mode_force_impedance_ctrl: FAILED **");
    end
    $finish;
  end

endmodule
